### sv/socket_report_deframer_assert.svh
// Assertion macros used by the socket report deframer parser RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SOCKET_REPORT_DEFRAMER_ASSERT_SVH
`define SOCKET_REPORT_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srd_pkg.sv
// Package for the socket report deframer: payload structs, phase codes,
// character constants and the header text. No dependencies.
package srd_pkg;

  localparam int unsigned RxByteW  = 8;
  localparam int unsigned SocketW  = 16;
  localparam int unsigned LenW     = 10;
  localparam int unsigned LenAccW  = 11;

  localparam logic [3:0]         HdrLen       = 4'd8;
  localparam logic [SocketW-1:0] SocketMax    = 16'hFFFF;
  localparam logic [LenAccW-1:0] LenAccMax    = 11'd2047;
  localparam logic [LenW-1:0]    MaxLenReset  = 10'd1023;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SOCKET   = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_NEWLINES = 3'd3,
    PH_PAYLOAD  = 3'd4
  } srd_phase_e;

  typedef struct packed {
    logic [RxByteW-1:0] rx_byte;
  } srd_rx_t;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               byte_valid;
    logic               last_of_packet;
    logic [SocketW-1:0] socket_id;
    logic [LenW-1:0]    packet_length;
  } srd_rpt_t;

  // One parse step: whether the byte produced a result, and that result.
  typedef struct packed {
    logic     emit;
    srd_rpt_t rpt;
  } srd_step_t;

  // Header text "+SKTRPT=", one character per position.
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h53;
      3'd2:    ch = 8'h4B;
      3'd3:    ch = 8'h54;
      3'd4:    ch = 8'h52;
      3'd5:    ch = 8'h50;
      3'd6:    ch = 8'h54;
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

endpackage

### sv/srd_if.sv
// Valid/ready channel interfaces for received bytes and report results.
// Depends on srd_pkg for the payload structs.
interface srd_rx_if import srd_pkg::*; ();
  logic    valid;
  logic    ready;
  srd_rx_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface srd_rpt_if import srd_pkg::*; ();
  logic     valid;
  logic     ready;
  srd_rpt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/srd_parser.sv
// Per-byte parser: header match, decimal fields, line-feed skip, payload count.
// Depends on srd_pkg and socket_report_deframer_assert.svh.
`include "socket_report_deframer_assert.svh"

module srd_parser import srd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_wdata_i,
  input  logic                accept_i,
  input  logic [RxByteW-1:0]  rx_byte_i,
  output srd_step_t           step_o
);

  srd_phase_e         phase_q, phase_d;
  logic [3:0]         hdr_cnt_q, hdr_cnt_d;
  logic [SocketW-1:0] sock_q, sock_d;
  logic [LenAccW-1:0] len_q, len_d;
  logic [1:0]         nl_cnt_q, nl_cnt_d;
  logic [LenW-1:0]    passed_q, passed_d;
  logic [LenW-1:0]    max_len_q;

  logic               is_digit;
  logic [3:0]         digit;
  logic [19:0]        sock_x10;
  logic [14:0]        len_x10;
  logic [SocketW-1:0] sock_sat;
  logic [LenAccW-1:0] len_sat;
  logic [3:0]         hdr_next;
  logic [1:0]         nl_next;
  logic               pay_valid;
  logic [LenW-1:0]    passed_next;
  logic               pay_last;

  assign is_digit = rx_byte_i inside {[ChZero:ChNine]};
  assign digit    = 4'(rx_byte_i - ChZero);

  // acc * 10 + digit as shift-and-add
  assign sock_x10 = {1'b0, sock_q, 3'b000} + {3'b000, sock_q, 1'b0} + {16'b0, digit};
  assign len_x10  = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {11'b0, digit};
  assign sock_sat = (sock_x10 > {4'b0, SocketMax}) ? SocketMax : sock_x10[SocketW-1:0];
  assign len_sat  = (len_x10 > {4'b0, LenAccMax}) ? LenAccMax : len_x10[LenAccW-1:0];

  // Restart on mismatch; a '+' counts as the first header character.
  assign hdr_next = (hdr_cnt_q < HdrLen && rx_byte_i == hdr_char(hdr_cnt_q[2:0]))
                  ? hdr_cnt_q + 4'd1
                  : ((rx_byte_i == ChPlus) ? 4'd1 : 4'd0);

  assign nl_next = (rx_byte_i == ChLf && nl_cnt_q < 2'd2) ? nl_cnt_q + 2'd1 : nl_cnt_q;

  assign pay_valid   = {1'b0, passed_q} < len_q;
  assign passed_next = pay_valid ? passed_q + LenW'(1) : passed_q;
  assign pay_last    = {1'b0, passed_next} >= len_q;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    sock_d    = sock_q;
    len_d     = len_q;
    nl_cnt_d  = nl_cnt_q;
    passed_d  = passed_q;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (hdr_next >= HdrLen) begin
            hdr_cnt_d = '0;
            sock_d    = '0;
            len_d     = '0;
            phase_d   = PH_SOCKET;
          end else begin
            hdr_cnt_d = hdr_next;
          end
        end
        PH_SOCKET: begin
          if (rx_byte_i == ChComma) begin
            phase_d = PH_LENGTH;
          end else if (is_digit) begin
            sock_d = sock_sat;
          end
        end
        PH_LENGTH: begin
          if (rx_byte_i == ChComma) begin
            if (len_q > {1'b0, max_len_q}) begin
              len_d = {1'b0, max_len_q};
            end
            nl_cnt_d = '0;
            phase_d  = PH_NEWLINES;
          end else if (is_digit) begin
            len_d = len_sat;
          end
        end
        PH_NEWLINES: begin
          nl_cnt_d = nl_next;
          if (nl_next >= 2'd2) begin
            passed_d = '0;
            phase_d  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_d   = PH_HUNT;
            hdr_cnt_d = '0;
            sock_d    = '0;
            len_d     = '0;
            nl_cnt_d  = '0;
            passed_d  = '0;
          end else begin
            passed_d = passed_next;
          end
        end
        default: begin
          phase_d   = PH_HUNT;
          hdr_cnt_d = '0;
          sock_d    = '0;
          len_d     = '0;
          nl_cnt_d  = '0;
          passed_d  = '0;
        end
      endcase
    end
  end

  always_comb begin
    step_o                     = '0;
    step_o.emit                = accept_i && (phase_q == PH_PAYLOAD);
    step_o.rpt.payload_byte    = pay_valid ? rx_byte_i : 8'h00;
    step_o.rpt.byte_valid      = pay_valid;
    step_o.rpt.last_of_packet  = pay_last;
    step_o.rpt.socket_id       = sock_q;
    step_o.rpt.packet_length   = len_q[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      hdr_cnt_q <= '0;
      sock_q    <= '0;
      len_q     <= '0;
      nl_cnt_q  <= '0;
      passed_q  <= '0;
      max_len_q <= MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      sock_q    <= sock_d;
      len_q     <= len_d;
      nl_cnt_q  <= nl_cnt_d;
      passed_q  <= passed_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  `SRD_ASSERT_IMPLIES(a_hunt_progress, phase_q == PH_HUNT, hdr_cnt_q < HdrLen,
                      "header count out of range")
  `SRD_ASSERT_IMPLIES(a_passed_bound, phase_q == PH_PAYLOAD,
                      ({1'b0, passed_q} <= len_q), "payload count past length")
  `SRD_ASSERT_NEXT(a_last_to_hunt, step_o.emit && step_o.rpt.last_of_packet,
                   phase_q == PH_HUNT && passed_q == '0, "no return to hunt after last")
  `SRD_ASSERT_IMPLIES(a_emit_in_payload, step_o.emit,
                      phase_q == PH_PAYLOAD && len_q[LenAccW-1] == 1'b0,
                      "result outside payload phase")

endmodule

### sv/srd_out_reg.sv
// Result register between the parser and the report channel.
// Depends on srd_pkg and srd_if.
module srd_out_reg import srd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  srd_step_t        step_i,
  output logic             in_ready_o,
  srd_rpt_if.source        rpt
);

  logic     valid_q, valid_d;
  srd_rpt_t data_q, data_d;

  // Load whenever the held result is absent or leaving this cycle.
  assign in_ready_o = !valid_q || rpt.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = accept_i && step_i.emit;
    end
    if (accept_i && step_i.emit) begin
      data_d = step_i.rpt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign rpt.valid   = valid_q;
  assign rpt.payload = data_q;

endmodule

### sv/socket_report_deframer.sv
// Socket report deframer: one serial byte in per cycle, payload bytes out.
// A payload byte appears on rpt in the cycle after its rx transfer.
// Throughput: one byte per cycle, set by the single parse step per byte.
// rx stalls only while a held result waits on rpt.ready.
// Reset (async, active low) returns to header hunt, clears all counters and
// sets the length cap to 1023.
module socket_report_deframer import srd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  srd_rx_if.sink          rx,
  srd_rpt_if.source       rpt
);

  logic      accept;
  logic      in_ready;
  srd_step_t step;

  // A byte transfers whenever the result register can take what it yields.
  assign rx.ready = in_ready;
  assign accept   = rx.valid && in_ready;

  // Parse: header hunt, socket id, length, two line feeds, then payload.
  srd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx.payload.rx_byte),
    .step_o      (step)
  );

  // Hold each result until the report channel takes it.
  srd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .step_i     (step),
    .in_ready_o (in_ready),
    .rpt        (rpt)
  );

endmodule

### bench/tb_top.sv
// Self-checking bench for socket_report_deframer: drives serial bytes on rx,
// predicts every report result in step with each rx transfer and checks rpt.
// Depends on srd_pkg, the srd_rx_if/srd_rpt_if interfaces and the block RTL.
module tb_top;
  import srd_pkg::*;

  // Transfer-free cycles that the watchdog tolerates; covers the long
  // receiver hold-off below with plenty of margin.
  localparam int unsigned StallLimit   = 2000;
  // Cycles to let pass after the last expected result before touching the
  // length cap or ending the run.
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned RandomShare  = 200;
  localparam string       HdrText      = "+SKTRPT=";

  typedef logic [7:0] byte_q_t[$];

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  srd_rx_if  rx_ch ();
  srd_rpt_if rpt_ch ();

  socket_report_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx          (rx_ch),
    .rpt         (rpt_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the parser state, advanced once per accepted rx transfer.
  // ---------------------------------------------------------------------------
  srd_phase_e  m_phase  = PH_HUNT;
  int unsigned m_hdr    = 0;
  int unsigned m_sock   = 0;
  int unsigned m_len    = 0;
  int unsigned m_nl     = 0;
  int unsigned m_passed = 0;
  int unsigned m_cap    = MaxLenReset;

  srd_rpt_t    pending_reports[$];
  int unsigned parsed_bytes   = 0;
  int unsigned mismatch_count = 0;
  int unsigned snd_idle_pct   = 35;
  int unsigned rcv_idle_pct   = 50;
  int unsigned hold_off_request = 0;
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;

  // Advance the shadow parser by one byte and return the result it causes.
  function automatic srd_step_t parse_byte(input logic [7:0] b);
    srd_step_t   st;
    logic        is_digit;
    logic        carries;
    int unsigned acc;
    st       = '0;
    is_digit = (b >= ChZero) && (b <= ChNine);
    case (m_phase)
      PH_HUNT: begin
        // Sliding match: a mismatch restarts, but a '+' opens a new attempt.
        if (b == 8'(HdrText[m_hdr])) m_hdr = m_hdr + 1;
        else m_hdr = (b == ChPlus) ? 1 : 0;
        if (m_hdr >= HdrLen) begin
          m_hdr   = 0;
          m_sock  = 0;
          m_len   = 0;
          m_phase = PH_SOCKET;
        end
      end
      PH_SOCKET: begin
        if (b == ChComma) begin
          m_phase = PH_LENGTH;
        end else if (is_digit) begin
          acc    = m_sock * 10 + (b - ChZero);
          m_sock = (acc > SocketMax) ? SocketMax : acc;
        end
      end
      PH_LENGTH: begin
        if (b == ChComma) begin
          // The cap in force now sticks to this packet.
          if (m_len > m_cap) m_len = m_cap;
          m_nl    = 0;
          m_phase = PH_NEWLINES;
        end else if (is_digit) begin
          acc   = m_len * 10 + (b - ChZero);
          m_len = (acc > LenAccMax) ? LenAccMax : acc;
        end
      end
      PH_NEWLINES: begin
        if (b == ChLf && m_nl < 2) m_nl = m_nl + 1;
        if (m_nl >= 2) begin
          m_passed = 0;
          m_phase  = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        carries = 1'b0;
        if (m_passed < m_len) begin
          m_passed = m_passed + 1;
          carries  = 1'b1;
        end
        st.emit                   = 1'b1;
        st.rpt.payload_byte       = carries ? b : 8'h00;
        st.rpt.byte_valid         = carries;
        st.rpt.last_of_packet     = (m_passed >= m_len);
        st.rpt.socket_id          = m_sock[SocketW-1:0];
        st.rpt.packet_length      = m_len[LenW-1:0];
        if (st.rpt.last_of_packet) begin
          m_phase  = PH_HUNT;
          m_hdr    = 0;
          m_sock   = 0;
          m_len    = 0;
          m_nl     = 0;
          m_passed = 0;
        end
      end
      default: begin
        m_phase = PH_HUNT;
      end
    endcase
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: one byte per call, returns at the edge of its transfer with
  // valid still high so that back-to-back calls keep the channel busy.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    srd_step_t st;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid           <= 1'b1;
    rx_ch.payload.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    // Bytes that reach past the header hunt count as real work.
    if (m_phase != PH_HUNT) parsed_bytes++;
    st = parse_byte(b);
    if (st.emit) pending_reports.push_back(st.rpt);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  // Finish whatever payload the shadow parser is waiting for; a zero-length
  // packet still takes one byte for its end marker.
  task automatic send_payload();
    int unsigned n;
    n = 0;
    if (m_phase == PH_PAYLOAD) n = (m_len == 0) ? 1 : m_len - m_passed;
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait for every predicted result and let the pipe settle.
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the length cap while the block is quiet.
  task automatic set_length_cap(input logic [LenW-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    m_cap = cap;
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= ChZero && b <= ChNine) || b == ChComma);
    return b;
  endfunction

  function automatic logic [7:0] not_lf_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChLf);
    return b;
  endfunction

  // Append a decimal field with stray non-digits mixed in, then its comma.
  task automatic add_field(ref byte_q_t frame, input string digits);
    for (int i = 0; i < digits.len(); i++) begin
      if ($urandom_range(0, 7) == 0) frame.push_back(filler_byte());
      frame.push_back(digits[i]);
    end
    if ($urandom_range(0, 7) == 0) frame.push_back(filler_byte());
    frame.push_back(ChComma);
  endtask

  // One report with random content; now and then cut short to leave the
  // parser mid-frame so the next report has to recover from it.
  task automatic send_random_report();
    byte_q_t     frame;
    string       sock_txt;
    string       len_txt;
    int unsigned cut;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0:       sock_txt = "";
      1:       sock_txt = $sformatf("%0d", $urandom_range(0, 65535));
      2:       sock_txt = $sformatf("%0d%0d", $urandom_range(100000, 999999),
                                    $urandom_range(0, 9));
      default: sock_txt = $sformatf("%0d", $urandom_range(0, 99));
    endcase
    case ($urandom_range(0, 9))
      0:       len_txt = "";
      1:       len_txt = $sformatf("%0d", $urandom_range(13, 40));
      // Overflowing lengths only while the cap keeps the packet short.
      2:       len_txt = (m_cap <= 40) ? $sformatf("%0d", $urandom_range(3000, 99999))
                                       : $sformatf("%0d", $urandom_range(0, 12));
      default: len_txt = $sformatf("%0d", $urandom_range(0, 12));
    endcase
    for (int i = 0; i < HdrText.len(); i++) frame.push_back(HdrText[i]);
    add_field(frame, sock_txt);
    add_field(frame, len_txt);
    repeat ($urandom_range(0, 3)) frame.push_back(not_lf_byte());
    frame.push_back(ChLf);
    repeat ($urandom_range(0, 3)) frame.push_back(not_lf_byte());
    frame.push_back(ChLf);
    cut = frame.size();
    if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < cut; i++) send_byte(frame[i]);
    send_payload();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header matcher restarts, stray characters in the fields, line feeds
  // separated by junk, and payload bytes at both extremes.
  task automatic test_header_and_fields();
    send_text("++SKT+SKTRPX+SKTRPT=x1y2,b2,\r\nz\n");
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // Socket id saturates; a '+' inside the payload is just data.
  task automatic test_socket_saturation();
    send_text("+SKTRPT=9999999,1,\n\n");
    send_byte(ChPlus);
  endtask

  // Zero length: the next byte turns into an empty end marker.
  task automatic test_zero_length();
    send_text("+SKTRPT=4,0,\n\n");
    send_byte(8'h41);
  endtask

  // Cap extremes: cap 0 empties any packet; an overflowing length field
  // saturates and is then cut down to the cap.
  task automatic test_length_cap();
    set_length_cap(10'd0);
    send_text("+SKTRPT=5,3,\n\n");
    send_payload();
    set_length_cap(10'd1);
    send_text("+SKTRPT=0,7,\n\n");
    send_payload();
    set_length_cap(10'd9);
    send_text("+SKTRPT=65535,99999,\r\n\r\n");
    send_payload();
  endtask

  // A cap written after the length comma must not touch the open packet.
  task automatic test_cap_mid_packet();
    set_length_cap(10'd20);
    send_text("+SKTRPT=8,30,");
    set_length_cap(10'd2);
    send_text("\n\n");
    send_payload();
  endtask

  // Hold rpt off for a long stretch while rx keeps offering bytes, so the
  // held result backs up into the input.
  task automatic test_backpressure();
    snd_idle_pct = 0;
    set_length_cap(10'd1023);
    send_text("+SKTRPT=3,40,\n\n");
    hold_off_request = HoldOffLen;
    send_payload();
    snd_idle_pct = 35;
  endtask

  // Mostly well-formed reports with random content, in three idling modes,
  // each under its own cap.
  task automatic test_random_reports();
    int unsigned goal;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle_pct = 35;
          rcv_idle_pct = 50;
          set_length_cap(10'($urandom_range(0, 15)));
        end
        1: begin
          snd_idle_pct = 50;
          rcv_idle_pct = 35;
          set_length_cap(10'd1023);
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          set_length_cap(10'd8);
        end
      endcase
      goal = parsed_bytes + RandomShare;
      while (parsed_bytes < goal) send_random_report();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_off_request != 0) begin
      stall_left       = hold_off_request;
      hold_off_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Compare each rpt transfer with the oldest prediction.
  always @(posedge clk_i) begin
    srd_rpt_t want;
    if (rst_ni && rpt_ch.valid && rpt_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: payload_byte %0d", rpt_ch.payload.payload_byte);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("payload_byte", want.payload_byte, rpt_ch.payload.payload_byte);
        check_field("byte_valid", want.byte_valid, rpt_ch.payload.byte_valid);
        check_field("last_of_packet", want.last_of_packet, rpt_ch.payload.last_of_packet);
        check_field("socket_id", want.socket_id, rpt_ch.payload.socket_id);
        check_field("packet_length", want.packet_length, rpt_ch.payload.packet_length);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.payload = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_header_and_fields();
    test_socket_saturation();
    test_zero_length();
    test_length_cap();
    test_cap_mid_packet();
    test_backpressure();
    test_random_reports();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
